// ----- rtl/psci_pkg.sv -----
// Shared constants, register codes and types of the charge integrator.
package psci_pkg;

    localparam int ADC_W    = 16;
    localparam int CFG_W    = 10;
    localparam int SEL_W    = 5;
    localparam int SUM_W    = 27;
    localparam int CNT_W    = 11;
    localparam int CHARGE_W = 32;

    localparam int DEF_CHANNELS    = 32;
    localparam int DEF_MAX_SAMPLES = 1024;

    // Event queue depth, a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_CHANNEL_SELECT = 3'd0;
    localparam logic [2:0] REG_PED_FIRST      = 3'd1;
    localparam logic [2:0] REG_PED_LAST       = 3'd2;
    localparam logic [2:0] REG_INT_FIRST      = 3'd3;
    localparam logic [2:0] REG_INT_LAST       = 3'd4;

    localparam logic [SEL_W-1:0] RST_CHANNEL_SELECT = 5'd0;
    localparam logic [CFG_W-1:0] RST_PED_FIRST      = 10'd1;
    localparam logic [CFG_W-1:0] RST_PED_LAST       = 10'd50;
    localparam logic [CFG_W-1:0] RST_INT_FIRST      = 10'd50;
    localparam logic [CFG_W-1:0] RST_INT_LAST       = 10'd399;

    typedef struct packed {
        logic [SEL_W-1:0] channel_select;
        logic [CFG_W-1:0] ped_first;
        logic [CFG_W-1:0] ped_last;
        logic [CFG_W-1:0] int_first;
        logic [CFG_W-1:0] int_last;
    } t_cfg;

    typedef struct packed {
        logic signed [SUM_W-1:0] bsum;
        logic signed [SUM_W-1:0] wsum;
        logic [CNT_W-1:0]        nb;
        logic [CNT_W-1:0]        nw;
        logic                    err;
    } t_evt;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ----- rtl/psci_in_if.sv -----
// Input channel: one ADC word and its end-of-event mark per item.
interface psci_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [psci_pkg::ADC_W-1:0]   adc_word;
    logic                                end_of_event;

    modport source (output valid, output adc_word, output end_of_event, input ready);
    modport sink   (input valid, input adc_word, input end_of_event, output ready);
endinterface

// ----- rtl/psci_out_if.sv -----
// Output channel: one charge result per event.
interface psci_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psci_pkg::CHARGE_W-1:0] charge;
    logic                                 window_error;

    modport source (output valid, output charge, output window_error, input ready);
    modport sink   (input valid, input charge, input window_error, output ready);
endinterface

// ----- rtl/psci_cfg.sv -----
// APB register file holding the channel select and window bounds.
module psci_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psci_pkg::APB_AW-1:0]   paddr,
    input  logic [psci_pkg::APB_DW-1:0]   pwdata,
    output logic [psci_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output psci_pkg::t_cfg                o_cfg
);
    import psci_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_select <= RST_CHANNEL_SELECT;
            r_cfg.ped_first      <= RST_PED_FIRST;
            r_cfg.ped_last       <= RST_PED_LAST;
            r_cfg.int_first      <= RST_INT_FIRST;
            r_cfg.int_last       <= RST_INT_LAST;
        end else if (wr_en) begin
            case (idx)
                REG_CHANNEL_SELECT: r_cfg.channel_select <= pwdata[SEL_W-1:0];
                REG_PED_FIRST:      r_cfg.ped_first      <= pwdata[CFG_W-1:0];
                REG_PED_LAST:       r_cfg.ped_last       <= pwdata[CFG_W-1:0];
                REG_INT_FIRST:      r_cfg.int_first      <= pwdata[CFG_W-1:0];
                REG_INT_LAST:       r_cfg.int_last       <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CHANNEL_SELECT: prdata = APB_DW'(r_cfg.channel_select);
            REG_PED_FIRST:      prdata = APB_DW'(r_cfg.ped_first);
            REG_PED_LAST:       prdata = APB_DW'(r_cfg.ped_last);
            REG_INT_FIRST:      prdata = APB_DW'(r_cfg.int_first);
            REG_INT_LAST:       prdata = APB_DW'(r_cfg.int_last);
            default:            prdata = '0;
        endcase
    end
endmodule

// ----- rtl/psci_front.sv -----
// Front end: tracks sample and channel, accumulates both windows, closes each event.
module psci_front #(
    parameter int CHANNELS    = psci_pkg::DEF_CHANNELS,
    parameter int MAX_SAMPLES = psci_pkg::DEF_MAX_SAMPLES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psci_pkg::t_cfg      i_cfg,
    psci_in_if.sink             i_in_ch,
    input  psci_pkg::t_q_status i_q_status,
    output logic                o_push,
    output psci_pkg::t_evt      o_evt
);
    import psci_pkg::*;

    localparam int PW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TIW = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = (PW > SEL_W) ? PW : SEL_W;
    localparam int TW  = (TIW > CFG_W) ? TIW : CFG_W;

    logic [TIW-1:0]          r_time, n_time;
    logic [PW-1:0]           r_phase, n_phase;
    logic signed [SUM_W-1:0] r_bsum, n_bsum;
    logic signed [SUM_W-1:0] r_wsum, n_wsum;
    logic [CNT_W-1:0]        r_nb, n_nb;
    logic [CNT_W-1:0]        r_nw, n_nw;

    logic             accept;
    logic             running;
    logic             match;
    logic             in_ped;
    logic             in_int;
    logic             err;
    logic [CNT_W-1:0] ped_len;
    logic [CNT_W-1:0] int_len;

    assign i_in_ch.ready = !i_q_status.full;
    assign accept        = i_in_ch.valid && i_in_ch.ready;

    assign running = r_time < TIW'(MAX_SAMPLES);
    assign match   = running && (SW'(r_phase) == SW'(i_cfg.channel_select));
    assign in_ped  = (TW'(r_time) >= TW'(i_cfg.ped_first)) &&
                     (TW'(r_time) <= TW'(i_cfg.ped_last));
    assign in_int  = (TW'(r_time) >= TW'(i_cfg.int_first)) &&
                     (TW'(r_time) <= TW'(i_cfg.int_last));

    always_comb begin
        n_bsum  = r_bsum;
        n_nb    = r_nb;
        n_wsum  = r_wsum;
        n_nw    = r_nw;
        n_time  = r_time;
        n_phase = r_phase;
        if (match && in_ped) begin
            n_bsum = r_bsum + SUM_W'(i_in_ch.adc_word);
            n_nb   = r_nb + CNT_W'(1);
        end
        if (match && in_int) begin
            n_wsum = r_wsum + SUM_W'(i_in_ch.adc_word);
            n_nw   = r_nw + CNT_W'(1);
        end
        if (running) begin
            if (r_phase == PW'(CHANNELS - 1)) begin
                n_phase = '0;
                n_time  = r_time + TIW'(1);
            end else begin
                n_phase = r_phase + PW'(1);
            end
        end
    end

    // Lengths are meaningless for an empty window, but that case is flagged anyway.
    assign ped_len = CNT_W'(i_cfg.ped_last) - CNT_W'(i_cfg.ped_first) + CNT_W'(1);
    assign int_len = CNT_W'(i_cfg.int_last) - CNT_W'(i_cfg.int_first) + CNT_W'(1);
    assign err = (i_cfg.ped_first > i_cfg.ped_last) || (i_cfg.int_first > i_cfg.int_last) ||
                 (n_nb != ped_len) || (n_nw != int_len) || (n_nb == '0);

    assign o_push    = accept && i_in_ch.end_of_event;
    assign o_evt.bsum = n_bsum;
    assign o_evt.wsum = n_wsum;
    assign o_evt.nb   = n_nb;
    assign o_evt.nw   = n_nw;
    assign o_evt.err  = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_phase <= '0;
            r_bsum  <= '0;
            r_wsum  <= '0;
            r_nb    <= '0;
            r_nw    <= '0;
        end else if (accept) begin
            if (i_in_ch.end_of_event) begin
                r_time  <= '0;
                r_phase <= '0;
                r_bsum  <= '0;
                r_wsum  <= '0;
                r_nb    <= '0;
                r_nw    <= '0;
            end else begin
                r_time  <= n_time;
                r_phase <= n_phase;
                r_bsum  <= n_bsum;
                r_wsum  <= n_wsum;
                r_nb    <= n_nb;
                r_nw    <= n_nw;
            end
        end
    end
endmodule

// ----- rtl/psci_queue.sv -----
// Short queue of closed events between the front end and the divider.
module psci_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  psci_pkg::t_evt      i_evt,
    input  logic                i_pop,
    output psci_pkg::t_evt      o_evt,
    output psci_pkg::t_q_status o_status
);
    import psci_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_evt         r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    assign o_evt          = r_mem[r_rd];
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == (QAW + 1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QAW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QAW + 1)'(1);
            end
        end
    end
endmodule

// ----- rtl/psci_back.sv -----
// Back end: forms the scaled numerator and divides it bit-serially by the baseline count.
module psci_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psci_pkg::t_evt      i_evt,
    input  psci_pkg::t_q_status i_q_status,
    output logic                o_pop,
    psci_out_if.source          o_out_ch
);
    import psci_pkg::*;

    localparam int PROD_W = SUM_W + CNT_W + 1;
    localparam int DIV_W  = PROD_W + 1 + 4;
    localparam int DCW    = $clog2(DIV_W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]               r_state;
    t_evt                     r_evt;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic                     r_neg;
    logic [DIV_W-1:0]         r_q;
    logic [CNT_W-1:0]         r_rem;
    logic [DCW-1:0]           r_cnt;

    logic                       r_ovalid;
    logic signed [CHARGE_W-1:0] r_charge;
    logic                       r_oerr;

    logic signed [PROD_W:0]     diff;
    logic signed [DIV_W-1:0]    num;
    logic [CNT_W:0]             rem_sh;
    logic                       take;
    logic                       out_free;
    logic signed [CHARGE_W-1:0] sat;

    assign o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;
    assign out_free = !r_ovalid || o_out_ch.ready;

    assign diff   = (PROD_W + 1)'(r_p1) - (PROD_W + 1)'(r_p2);
    assign num    = DIV_W'(diff) <<< 4;
    assign rem_sh = {r_rem, r_q[DIV_W-1]};
    assign take   = rem_sh >= {1'b0, r_evt.nb};

    // The quotient magnitude is truncated toward zero and saturated, then the sign goes back on.
    always_comb begin
        if (!r_neg && (r_q > DIV_W'(32'h7FFF_FFFF))) begin
            sat = {1'b0, {(CHARGE_W - 1){1'b1}}};
        end else if (r_neg && (r_q > DIV_W'(32'h8000_0000))) begin
            sat = {1'b1, {(CHARGE_W - 1){1'b0}}};
        end else if (r_neg) begin
            sat = -$signed(r_q[CHARGE_W-1:0]);
        end else begin
            sat = $signed(r_q[CHARGE_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_evt <= i_evt;
                end
            end
            ST_MUL: begin
                r_p1 <= r_evt.bsum * $signed({1'b0, r_evt.nw});
                r_p2 <= r_evt.wsum * $signed({1'b0, r_evt.nb});
            end
            ST_SUB: begin
                r_neg <= num[DIV_W-1];
                r_q   <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
                r_rem <= '0;
            end
            ST_DIV: begin
                r_q <= {r_q[DIV_W-2:0], take};
                r_rem <= take ? CNT_W'(rem_sh - {1'b0, r_evt.nb}) : CNT_W'(rem_sh);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_FIN) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= i_evt.err ? ST_FIN : ST_MUL;
                    end
                end
                ST_MUL: r_state <= ST_SUB;
                ST_SUB: begin
                    r_cnt   <= DCW'(DIV_W);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - DCW'(1);
                    if (r_cnt == DCW'(1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_charge <= r_evt.err ? '0 : sat;
            r_oerr   <= r_evt.err;
        end
    end

    assign o_out_ch.valid        = r_ovalid;
    assign o_out_ch.charge       = r_charge;
    assign o_out_ch.window_error = r_oerr;
endmodule

// ----- rtl/pedestal_subtracted_charge_integrator_unit.sv -----
// Pedestal-subtracted charge integrator: one channel's baseline and window sums per event.
// Throughput: one ADC word per cycle while the queue is not full; input stalls while two
// closed events are queued. A closed event holds the divider through pop, multiply,
// subtract, the restoring divide steps of its 44-bit quotient and output; on a window
// error it goes straight from pop to output.
// Reset is synchronous and active low; it clears counters, sums, queue and divider state
// and loads the window registers with their defaults.
module pedestal_subtracted_charge_integrator_unit #(
    parameter int CHANNELS    = psci_pkg::DEF_CHANNELS,
    parameter int MAX_SAMPLES = psci_pkg::DEF_MAX_SAMPLES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psci_pkg::APB_AW-1:0] paddr,
    input  logic [psci_pkg::APB_DW-1:0] pwdata,
    output logic [psci_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    psci_in_if.sink                     i_in_ch,
    psci_out_if.source                  o_out_ch
);
    import psci_pkg::*;

    t_cfg      cfg;
    t_evt      push_evt;
    t_evt      head_evt;
    t_q_status q_status;
    logic      push;
    logic      pop;

    psci_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psci_front #(
        .CHANNELS    (CHANNELS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_ch    (i_in_ch),
        .i_q_status (q_status),
        .o_push     (push),
        .o_evt      (push_evt)
    );

    psci_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_evt    (push_evt),
        .i_pop    (pop),
        .o_evt    (head_evt),
        .o_status (q_status)
    );

    psci_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (head_evt),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out_ch   (o_out_ch)
    );

    // A closed event is never dropped against a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("event closed while the queue is full");

    // The divider only takes an event that is really waiting.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("divider popped an empty queue");

    // A closed event is waiting in the queue on the next cycle.
    a_event_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_status.empty)
        else $error("closed event missing from the queue");

    // A window error always comes with a zero charge.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.window_error) |-> (o_out_ch.charge == '0))
        else $error("window error with nonzero charge");
endmodule

// ----- bench/pedestal_subtracted_charge_integrator_unit_tb.sv -----
// Self-checking testbench of the pedestal-subtracted charge integrator with its own charge predictor.
`timescale 1ns / 1ps

module pedestal_subtracted_charge_integrator_unit_tb;
    import psci_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 60;
    localparam int NUM_CHANNELS = DEF_CHANNELS;
    localparam int NUM_SAMPLES  = DEF_MAX_SAMPLES;

    typedef struct {
        logic signed [CHARGE_W-1:0] charge;
        logic                       window_error;
    } t_charge_result;

    // Tracks the window settings and the running sums of the open event, and holds the
    // charges of closed events until the block delivers them.
    class charge_predictor;
        logic [SEL_W-1:0] chan_sel;
        logic [CFG_W-1:0] ped_lo;
        logic [CFG_W-1:0] ped_hi;
        logic [CFG_W-1:0] win_lo;
        logic [CFG_W-1:0] win_hi;
        int unsigned      sample_idx;
        int unsigned      chan_pos;
        int unsigned      ped_count;
        int unsigned      win_count;
        longint           ped_total;
        longint           win_total;
        t_charge_result   awaited[$];
        int               failures;

        function new();
            chan_sel = RST_CHANNEL_SELECT;
            ped_lo   = RST_PED_FIRST;
            ped_hi   = RST_PED_LAST;
            win_lo   = RST_INT_FIRST;
            win_hi   = RST_INT_LAST;
            failures = 0;
            clear_event();
        endfunction

        function void clear_event();
            sample_idx = 0;
            chan_pos   = 0;
            ped_count  = 0;
            win_count  = 0;
            ped_total  = 0;
            win_total  = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [APB_DW-1:0] val);
            case (idx)
                REG_CHANNEL_SELECT: chan_sel = val[SEL_W-1:0];
                REG_PED_FIRST:      ped_lo = val[CFG_W-1:0];
                REG_PED_LAST:       ped_hi = val[CFG_W-1:0];
                REG_INT_FIRST:      win_lo = val[CFG_W-1:0];
                REG_INT_LAST:       win_hi = val[CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void take_word(logic signed [ADC_W-1:0] adc, logic eoe);
            longint         num;
            longint         q;
            bit             bad;
            t_charge_result res;
            if (sample_idx < NUM_SAMPLES && chan_pos == chan_sel) begin
                if (sample_idx >= ped_lo && sample_idx <= ped_hi) begin
                    ped_total += adc;
                    ped_count++;
                end
                if (sample_idx >= win_lo && sample_idx <= win_hi) begin
                    win_total += adc;
                    win_count++;
                end
            end
            // Words past the last sample no longer move the counters.
            if (sample_idx < NUM_SAMPLES) begin
                if (chan_pos + 1 >= NUM_CHANNELS) begin
                    chan_pos = 0;
                    sample_idx++;
                end else begin
                    chan_pos++;
                end
            end
            if (!eoe) return;

            bad = (ped_lo > ped_hi) || (win_lo > win_hi);
            if (!bad)
                bad = (ped_count != int'(ped_hi) - int'(ped_lo) + 1) ||
                      (win_count != int'(win_hi) - int'(win_lo) + 1);
            q = 0;
            if (!bad && ped_count != 0) begin
                num = (longint'(win_count) * ped_total - longint'(ped_count) * win_total) * 16;
                q = num / longint'(ped_count);
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
            end else begin
                bad = 1'b1;
            end
            res.charge       = q[CHARGE_W-1:0];
            res.window_error = bad;
            awaited.insert(awaited.size(), res);
            clear_event();
        endfunction

        function void match_result(logic signed [CHARGE_W-1:0] charge, logic werr);
            t_charge_result want;
            if (awaited.size() == 0) begin
                $error("charge result with no closed event: charge=%0d window_error=%0b",
                       charge, werr);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (charge !== want.charge) begin
                $error("charge: expected %0d, actual %0d", want.charge, charge);
                failures++;
            end
            if (werr !== want.window_error) begin
                $error("window_error: expected %0b, actual %0b", want.window_error, werr);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    psci_in_if  in_ch ();
    psci_out_if out_ch ();

    charge_predictor predictor = new();
    bit              calm = 1'b0;
    int              words_sent = 0;
    int              cycles = 0;

    pedestal_subtracted_charge_integrator_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 26);
    endfunction

    function automatic logic signed [ADC_W-1:0] rand_adc();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return r[ADC_W-1:0];
        endcase
    endfunction

    // Result side: ready changes at the falling edge, results are taken at the rising edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            predictor.match_result(out_ch.charge, out_ch.window_error);
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_word(input logic signed [ADC_W-1:0] w, input logic eoe);
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.adc_word     <= w;
        in_ch.end_of_event <= eoe;
        do @(posedge i_clk); while (!in_ch.ready);
        predictor.take_word(w, eoe);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_event(input int len);
        for (int i = 0; i < len; i++)
            send_word(rand_adc(), i == len - 1);
    endtask

    // Holds the sender until every closed event has produced its charge.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (predictor.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] mask;
        mask = (idx == REG_CHANNEL_SELECT) ? APB_DW'((1 << SEL_W) - 1) : APB_DW'((1 << CFG_W) - 1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        predictor.set_reg(idx, val);
        @(negedge i_clk);
        // Read the register straight back.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (val & mask)) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, val & mask, prdata);
            predictor.failures++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper bits of each write carry junk that the register must drop.
    task automatic program_windows(input logic [31:0] sel, input logic [31:0] pf,
                                   input logic [31:0] pl, input logic [31:0] wf,
                                   input logic [31:0] wl);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(REG_CHANNEL_SELECT, {junk[31:SEL_W], sel[SEL_W-1:0]});
        write_reg(REG_PED_FIRST, {junk[31:CFG_W], pf[CFG_W-1:0]});
        write_reg(REG_PED_LAST, {junk[31:CFG_W], pl[CFG_W-1:0]});
        write_reg(REG_INT_FIRST, {junk[31:CFG_W], wf[CFG_W-1:0]});
        write_reg(REG_INT_LAST, {junk[31:CFG_W], wl[CFG_W-1:0]});
    endtask

    initial begin
        int          need;
        int          len;
        int          phase_no;
        int          start_words;
        logic [31:0] sel;
        logic [31:0] pf;
        logic [31:0] pl;
        logic [31:0] wf;
        logic [31:0] wl;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.adc_word     = '0;
        in_ch.end_of_event = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single-sample windows on channel zero, then each error case.
        program_windows(0, 0, 0, 0, 0);
        send_word(16'sh8000, 1'b1);
        send_word(16'sh7FFF, 1'b1);
        send_word(16'sh1234, 1'b0);
        send_word(16'shFFFF, 1'b1);
        drain();
        // The selected channel never comes before the event ends.
        program_windows(1, 0, 0, 0, 0);
        send_word(16'sh0005, 1'b1);
        drain();
        // Empty baseline window, then empty integration window.
        program_windows(0, 1023, 0, 0, 0);
        send_word(16'sh0000, 1'b1);
        drain();
        program_windows(0, 0, 0, 1023, 0);
        send_word(16'sh7FFF, 1'b1);
        drain();
        // Integration window reaches far past the end of a short event.
        program_windows(31, 0, 0, 0, 1023);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh4000, 1'b1);
        drain();

        // Random: short windows near the start of the event so events stay short.
        start_words  = words_sent;
        phase_no     = 0;
        while (words_sent - start_words < 1050) begin
            calm = (phase_no == 1);
            sel  = ($urandom_range(3) == 0) ? 31 : $urandom_range(31);
            pf   = $urandom_range(2);
            pl   = pf + $urandom_range(1);
            wf   = $urandom_range(2);
            wl   = wf + $urandom_range(1);
            if ($urandom_range(9) == 0) pf = pl + 1 + $urandom_range(3);
            if ($urandom_range(9) == 0) wf = wl + 1 + $urandom_range(3);
            program_windows(sel, pf, pl, wf, wl);
            need = ((pl > wl) ? pl : wl) * NUM_CHANNELS + sel + 1;
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(9) < 7)
                    len = need + $urandom_range(40);
                else
                    len = $urandom_range(1, need + 8);
                send_event(len);
            end
            drain();
            phase_no++;
        end
        calm = 1'b0;

        // Late windows on the last channel: the event ends long before the windows.
        program_windows(31, 1000, 1023, 1020, 1023);
        send_event(100);
        drain();

        if (predictor.failures == 0 && predictor.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
